// ===== rtl/c2u8_pkg.sv =====
// Shared types, charset codes, constants and UTF-8 helpers of the charset to UTF-8 transcoder.
package c2u8_pkg;

	typedef logic [20:0] cp_t;

	// One queue entry: the first code point is always present, the second one optionally.
	typedef struct packed {
		cp_t  cp0;
		logic has_cp1;
		cp_t  cp1;
	} cp_pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	localparam logic [2:0] MODE_ASCII   = 3'd0;
	localparam logic [2:0] MODE_LATIN1  = 3'd1;
	localparam logic [2:0] MODE_U16BE   = 3'd2;
	localparam logic [2:0] MODE_U16LE   = 3'd3;
	localparam logic [2:0] MODE_U16BOM  = 3'd4;
	localparam logic [2:0] MODE_U32     = 3'd5;

	localparam cp_t CP_REPLACEMENT = 21'h00fffd;
	localparam cp_t CP_QUESTION    = 21'h00003f;
	localparam cp_t CP_SUPP_BASE   = 21'h010000;

	localparam logic [31:0] CP_MAX32 = 32'h0010ffff;

	localparam logic [15:0] BOM16_BE      = 16'hfeff;
	localparam logic [15:0] BOM16_SWAPPED = 16'hfffe;
	localparam logic [31:0] BOM32_BE      = 32'h0000feff;
	localparam logic [31:0] BOM32_SWAPPED = 32'hfffe0000;

	localparam logic [15:0] HIGH_FIRST = 16'hd800;
	localparam logic [15:0] HIGH_LAST  = 16'hdbff;
	localparam logic [15:0] LOW_FIRST  = 16'hdc00;
	localparam logic [15:0] LOW_LAST   = 16'hdfff;

	localparam logic [7:0] ASCII_LAST = 8'h7f;

	function automatic logic is_high16(input logic [15:0] u);
		return (u >= HIGH_FIRST) && (u <= HIGH_LAST);
	endfunction

	function automatic logic is_low16(input logic [15:0] u);
		return (u >= LOW_FIRST) && (u <= LOW_LAST);
	endfunction

	function automatic cp_t pair_cp(input logic [15:0] hi, input logic [15:0] lo);
		return CP_SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
	endfunction

	// Number of UTF-8 bytes minus one.
	function automatic logic [1:0] utf8_len(input cp_t cp);
		logic [1:0] len;
		if (cp < 21'h000080) begin
			len = 2'd0;
		end else if (cp < 21'h000800) begin
			len = 2'd1;
		end else if (cp < 21'h010000) begin
			len = 2'd2;
		end else begin
			len = 2'd3;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_byte(input cp_t cp, input logic [1:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		case ({len, idx})
			4'b00_00: b = {1'b0, cp[6:0]};
			4'b01_00: b = {3'b110, cp[10:6]};
			4'b01_01: b = {2'b10, cp[5:0]};
			4'b10_00: b = {4'b1110, cp[15:12]};
			4'b10_01: b = {2'b10, cp[11:6]};
			4'b10_10: b = {2'b10, cp[5:0]};
			4'b11_00: b = {5'b11110, cp[20:18]};
			4'b11_01: b = {2'b10, cp[17:12]};
			4'b11_10: b = {2'b10, cp[11:6]};
			default:  b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/c2u8_ifs.sv =====
// Valid/ready channel interfaces for the raw input bytes and the UTF-8 output bytes.
interface c2u8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source(output valid, output in_byte, output string_end, input ready);
	modport sink(input valid, input in_byte, input string_end, output ready);
endinterface

interface c2u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source(output valid, output out_byte, output run_last, input ready);
	modport sink(input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/c2u8_front.sv =====
// Front end: accepts input bytes, gathers code units and decodes them into code points.
module c2u8_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [2:0]              cfg_wr_data,
	c2u8_in_if.sink                 in_ch,
	input  c2u8_pkg::fifo_status_t  fifo_st,
	output logic                    push,
	output c2u8_pkg::cp_pair_t      push_data
);
	import c2u8_pkg::*;

	logic [2:0]  mode_q;
	logic [23:0] unit_q, unit_d;
	logic [1:0]  fill_q, fill_d;
	logic [15:0] pend_q, pend_d;
	logic        high_q, high_d;
	logic        first_q, first_d;
	logic        endian_q, endian_d;

	logic        accept;
	logic [2:0]  mode_eff;
	logic [15:0] be16, le16, u16;
	logic [31:0] be32, le32, v32;
	cp_t         c32;
	logic        hi32, lo32;
	cp_t         cp0, cp1;
	logic [1:0]  cnt;

	assign in_ch.ready = !fifo_st.full;
	assign accept      = in_ch.valid && in_ch.ready;

	assign mode_eff = (mode_q > MODE_U32) ? MODE_ASCII : mode_q;
	assign be16 = {unit_q[7:0], in_ch.in_byte};
	assign le16 = {in_ch.in_byte, unit_q[7:0]};
	assign u16  = ((mode_eff == MODE_U16LE) || ((mode_eff == MODE_U16BOM) && endian_q))
		? le16 : be16;
	assign be32 = {unit_q, in_ch.in_byte};
	assign le32 = {in_ch.in_byte, unit_q[7:0], unit_q[15:8], unit_q[23:16]};
	assign v32  = endian_q ? le32 : be32;
	assign c32  = (v32 > CP_MAX32) ? CP_REPLACEMENT : v32[20:0];
	assign hi32 = (c32[20:16] == 5'd0) && is_high16(c32[15:0]);
	assign lo32 = (c32[20:16] == 5'd0) && is_low16(c32[15:0]);

	// Code points are appended in order; at most two come out of one byte.
	always_comb begin
		unit_d   = unit_q;
		fill_d   = fill_q;
		pend_d   = pend_q;
		high_d   = high_q;
		first_d  = first_q;
		endian_d = endian_q;
		cp0      = '0;
		cp1      = '0;
		cnt      = 2'd0;
		case (mode_eff)
			MODE_U16BE, MODE_U16LE, MODE_U16BOM: begin
				if (fill_q == 2'd0) begin
					unit_d = {16'h0000, in_ch.in_byte};
					fill_d = 2'd1;
				end else begin
					unit_d  = '0;
					fill_d  = 2'd0;
					first_d = 1'b0;
					if (first_q && (mode_eff == MODE_U16BOM)
							&& ((be16 == BOM16_BE) || (be16 == BOM16_SWAPPED))) begin
						endian_d = (be16 == BOM16_SWAPPED);
					end else if (high_q) begin
						high_d = 1'b0;
						pend_d = '0;
						cp0    = is_low16(u16) ? pair_cp(pend_q, u16) : CP_REPLACEMENT;
						cnt    = 2'd1;
					end else if (is_high16(u16)) begin
						pend_d = u16;
						high_d = 1'b1;
					end else begin
						cp0 = is_low16(u16) ? CP_REPLACEMENT : {5'd0, u16};
						cnt = 2'd1;
					end
				end
				if (in_ch.string_end && ((fill_d != 2'd0) || high_d)) begin
					if (cnt == 2'd0) cp0 = CP_REPLACEMENT;
					else cp1 = CP_REPLACEMENT;
					cnt = cnt + 2'd1;
				end
			end
			MODE_U32: begin
				if (fill_q != 2'd3) begin
					unit_d = {unit_q[15:0], in_ch.in_byte};
					fill_d = fill_q + 2'd1;
				end else begin
					unit_d  = '0;
					fill_d  = 2'd0;
					first_d = 1'b0;
					if (first_q && ((be32 == BOM32_BE) || (be32 == BOM32_SWAPPED))) begin
						endian_d = (be32 == BOM32_SWAPPED);
					end else if (high_q && lo32) begin
						high_d = 1'b0;
						pend_d = '0;
						cp0    = pair_cp(pend_q, c32[15:0]);
						cnt    = 2'd1;
					end else begin
						// A held high surrogate not followed by a low one becomes '?'.
						if (high_q) begin
							cp0 = CP_QUESTION;
							cnt = 2'd1;
						end
						high_d = 1'b0;
						pend_d = '0;
						if (hi32) begin
							pend_d = c32[15:0];
							high_d = 1'b1;
						end else begin
							if (cnt == 2'd0) cp0 = lo32 ? CP_QUESTION : c32;
							else cp1 = lo32 ? CP_QUESTION : c32;
							cnt = cnt + 2'd1;
						end
					end
				end
				if (in_ch.string_end && high_d) begin
					if (cnt == 2'd0) cp0 = CP_QUESTION;
					else cp1 = CP_QUESTION;
					cnt = cnt + 2'd1;
				end
				if (in_ch.string_end && (fill_d != 2'd0)) begin
					if (cnt == 2'd0) cp0 = CP_REPLACEMENT;
					else cp1 = CP_REPLACEMENT;
					cnt = cnt + 2'd1;
				end
			end
			default: begin
				cp0 = ((mode_eff == MODE_ASCII) && (in_ch.in_byte > ASCII_LAST))
					? CP_REPLACEMENT : {13'd0, in_ch.in_byte};
				cnt = 2'd1;
			end
		endcase
		if (in_ch.string_end) begin
			unit_d   = '0;
			fill_d   = 2'd0;
			pend_d   = '0;
			high_d   = 1'b0;
			first_d  = 1'b1;
			endian_d = 1'b0;
		end
	end

	assign push              = accept && (cnt != 2'd0);
	assign push_data.cp0     = cp0;
	assign push_data.has_cp1 = (cnt == 2'd2);
	assign push_data.cp1     = cp1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ASCII;
			unit_q   <= '0;
			fill_q   <= 2'd0;
			pend_q   <= '0;
			high_q   <= 1'b0;
			first_q  <= 1'b1;
			endian_q <= 1'b0;
		end else if (cfg_wr_en) begin
			// A charset change starts a new string.
			mode_q   <= cfg_wr_data;
			unit_q   <= '0;
			fill_q   <= 2'd0;
			pend_q   <= '0;
			high_q   <= 1'b0;
			first_q  <= 1'b1;
			endian_q <= 1'b0;
		end else if (accept) begin
			unit_q   <= unit_d;
			fill_q   <= fill_d;
			pend_q   <= pend_d;
			high_q   <= high_d;
			first_q  <= first_d;
			endian_q <= endian_d;
		end
	end

endmodule

// ===== rtl/c2u8_fifo.sv =====
// Short queue of decoded code point entries between the front end and the UTF-8 serializer.
module c2u8_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  c2u8_pkg::cp_pair_t      push_data,
	input  logic                    pop,
	output c2u8_pkg::cp_pair_t      head,
	output c2u8_pkg::fifo_status_t  st
);
	import c2u8_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cp_pair_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head     = mem_q[rd_ptr_q];
	assign st.full  = (count_q == CNT_W'(DEPTH));
	assign st.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && st.full))
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && st.empty))
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow a lone push");

endmodule

// ===== rtl/c2u8_back.sv =====
// Back end: queued code points to UTF-8 bytes in an output register, one per cycle unless stalled.
module c2u8_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  c2u8_pkg::cp_pair_t      head,
	input  c2u8_pkg::fifo_status_t  fifo_st,
	output logic                    pop,
	c2u8_out_if.source              out_ch
);
	import c2u8_pkg::*;

	logic       sel_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	cp_t        cur_cp;
	logic [1:0] cur_len;
	logic       cp_done;
	logic       entry_done;
	logic       load;

	assign cur_cp     = sel_q ? head.cp1 : head.cp0;
	assign cur_len    = utf8_len(cur_cp);
	assign cp_done    = (idx_q == cur_len);
	assign entry_done = cp_done && (sel_q || !head.has_cp1);
	assign load       = !fifo_st.empty && (!out_valid_q || out_ch.ready);
	assign pop        = load && entry_done;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= utf8_byte(cur_cp, cur_len, idx_q);
			run_last_q <= entry_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (entry_done) begin
					sel_q <= 1'b0;
					idx_q <= 2'd0;
				end else if (cp_done) begin
					sel_q <= 1'b1;
					idx_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/charset_to_utf8_transcoder_core.sv =====
// Top level of the charset to UTF-8 transcoder: front end, code point queue and UTF-8 serializer.
//
// Bytes of a string enter on in_ch, the final byte flagged by string_end, and are decoded under
// the charset in the mode register (0 ASCII, 1 Latin-1, 2 UTF-16 BE, 3 UTF-16 LE, 4 UTF-16 with
// BOM detection, 5 UTF-32; 6 and 7 act as ASCII); writing the register also starts a new string.
// The front end takes one input byte per cycle whenever the code point queue has room, and a byte
// that completes no character produces no output. The serializer sends one UTF-8 byte per cycle
// on out_ch while the queue holds an entry and out_ch is not stalled, with run_last on the final
// byte caused by each input byte, so the sustained input rate is set by the serializer, which
// sends two bytes for each Latin-1 byte above 0x7f and up to five for the worst UTF-32 byte. The
// first output byte of an input byte passes through the queue entry and then the output register.
module charset_to_utf8_transcoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	c2u8_in_if.sink     in_ch,
	c2u8_out_if.source  out_ch
);
	import c2u8_pkg::*;

	logic         push;
	logic         pop;
	cp_pair_t     push_data;
	cp_pair_t     head;
	fifo_status_t fifo_st;

	c2u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.fifo_st     (fifo_st),
		.push        (push),
		.push_data   (push_data)
	);

	c2u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.st        (fifo_st)
	);

	c2u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.fifo_st (fifo_st),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== sim/charset_to_utf8_transcoder_core_tb.sv =====
// Self-checking testbench for the charset to UTF-8 transcoder core with a built-in decoder model.
`timescale 1ns / 100ps

module charset_to_utf8_transcoder_core_tb;
	import c2u8_pkg::*;

	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int RANDOM_BYTES = 105;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic        wr;
		logic [2:0]  mode;
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		logic [2:0]  n;
		logic [31:0] want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_wr_data;

	c2u8_in_if in_ch();
	c2u8_out_if out_ch();

	charset_to_utf8_transcoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decoder state, mirrored from the block's string state.
	logic [2:0]  cs_mode;
	logic [23:0] acc_bytes;
	logic [1:0]  acc_fill;
	logic [15:0] held_high;
	logic        held_valid;
	logic        at_first;
	logic        bom_little;

	logic [7:0] step_bytes[$];
	logic [7:0] str_bytes[$];
	out_item_t  utf8_due[$];
	step_row_t  plan[$];

	logic burst;
	int mismatches = 0;
	int bytes_sent = 0;
	int bytes_checked = 0;
	int mode_writes = 0;
	int cycle_count = 0;

	function automatic void clear_string_state();
		acc_bytes = '0;
		acc_fill = '0;
		held_high = '0;
		held_valid = 1'b0;
		at_first = 1'b1;
		bom_little = 1'b0;
	endfunction

	function automatic logic in_span(input logic [31:0] v, input logic [15:0] lo,
			input logic [15:0] hi);
		return (v >= {16'h0, lo}) && (v <= {16'h0, hi});
	endfunction

	function automatic cp_t surrogate_join(input logic [15:0] hi, input logic [15:0] lo);
		logic [9:0] h;
		logic [9:0] l;
		h = 10'(hi - HIGH_FIRST);
		l = 10'(lo - LOW_FIRST);
		return CP_SUPP_BASE + {1'b0, h, l};
	endfunction

	function automatic void emit_cp(input cp_t cp);
		if (cp < 21'h000080) begin
			step_bytes.push_back({1'b0, cp[6:0]});
		end else if (cp < 21'h000800) begin
			step_bytes.push_back({3'b110, cp[10:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h010000) begin
			step_bytes.push_back({4'b1110, cp[15:12]});
			step_bytes.push_back({2'b10, cp[11:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			step_bytes.push_back({5'b11110, cp[20:18]});
			step_bytes.push_back({2'b10, cp[17:12]});
			step_bytes.push_back({2'b10, cp[11:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void decode_unit16(input logic [15:0] u);
		if (held_valid) begin
			held_valid = 1'b0;
			if (in_span({16'h0, u}, LOW_FIRST, LOW_LAST)) begin
				emit_cp(surrogate_join(held_high, u));
			end else begin
				emit_cp(CP_REPLACEMENT);
			end
			held_high = '0;
		end else if (in_span({16'h0, u}, HIGH_FIRST, HIGH_LAST)) begin
			held_high = u;
			held_valid = 1'b1;
		end else if (in_span({16'h0, u}, LOW_FIRST, LOW_LAST)) begin
			emit_cp(CP_REPLACEMENT);
		end else begin
			emit_cp({5'b0, u});
		end
	endfunction

	function automatic void decode_unit32(input logic [31:0] v);
		logic [31:0] cp;
		cp = (v > CP_MAX32) ? {11'b0, CP_REPLACEMENT} : v;
		if (held_valid) begin
			held_valid = 1'b0;
			held_high = (in_span(cp, LOW_FIRST, LOW_LAST)) ? held_high : '0;
			if (in_span(cp, LOW_FIRST, LOW_LAST)) begin
				emit_cp(surrogate_join(held_high, cp[15:0]));
				held_high = '0;
				return;
			end
			emit_cp(CP_QUESTION);
		end
		if (in_span(cp, HIGH_FIRST, HIGH_LAST)) begin
			held_high = cp[15:0];
			held_valid = 1'b1;
		end else if (in_span(cp, LOW_FIRST, LOW_LAST)) begin
			emit_cp(CP_QUESTION);
		end else begin
			emit_cp(cp[20:0]);
		end
	endfunction

	// Works out the UTF-8 bytes that one accepted input byte causes, into step_bytes.
	function automatic void transcode_byte(input logic [7:0] b, input logic fin);
		logic [2:0]  m;
		logic [15:0] be16;
		logic [15:0] le16;
		logic [31:0] be32;
		logic [31:0] le32;
		m = (cs_mode > MODE_U32) ? MODE_ASCII : cs_mode;
		step_bytes.delete();
		if (m == MODE_ASCII || m == MODE_LATIN1) begin
			emit_cp((m == MODE_ASCII && b > ASCII_LAST) ? CP_REPLACEMENT : {13'b0, b});
		end else if (m != MODE_U32) begin
			if (acc_fill == 2'd0) begin
				acc_bytes = {16'h0, b};
				acc_fill = 2'd1;
			end else begin
				be16 = {acc_bytes[7:0], b};
				le16 = {b, acc_bytes[7:0]};
				acc_bytes = '0;
				acc_fill = 2'd0;
				if (at_first && m == MODE_U16BOM &&
						(be16 == BOM16_BE || be16 == BOM16_SWAPPED)) begin
					bom_little = (be16 == BOM16_SWAPPED);
				end else begin
					decode_unit16((m == MODE_U16LE || (m == MODE_U16BOM && bom_little)) ?
						le16 : be16);
				end
				at_first = 1'b0;
			end
			if (fin && (acc_fill != 2'd0 || held_valid)) begin
				emit_cp(CP_REPLACEMENT);
			end
		end else begin
			if (acc_fill < 2'd3) begin
				acc_bytes = {acc_bytes[15:0], b};
				acc_fill = acc_fill + 2'd1;
			end else begin
				be32 = {acc_bytes, b};
				le32 = {be32[7:0], be32[15:8], be32[23:16], be32[31:24]};
				acc_bytes = '0;
				acc_fill = 2'd0;
				if (at_first && (be32 == BOM32_BE || be32 == BOM32_SWAPPED)) begin
					bom_little = (be32 == BOM32_SWAPPED);
				end else begin
					decode_unit32(bom_little ? le32 : be32);
				end
				at_first = 1'b0;
			end
			if (fin) begin
				if (held_valid) begin
					emit_cp(CP_QUESTION);
				end
				if (acc_fill != 2'd0) begin
					emit_cp(CP_REPLACEMENT);
				end
			end
		end
		if (fin) begin
			clear_string_state();
		end
	endfunction

	function automatic void add_row(input logic wr, input logic [2:0] mode,
			input logic [7:0] data, input logic fin, input logic typed, input logic [2:0] n,
			input logic [31:0] want);
		step_row_t r;
		r.wr = wr;
		r.mode = mode;
		r.data = data;
		r.fin = fin;
		r.typed = typed;
		r.n = n;
		r.want = want;
		plan.push_back(r);
	endfunction

	function automatic void put16(input logic [15:0] u, input logic little);
		if (little) begin
			str_bytes.push_back(u[7:0]);
			str_bytes.push_back(u[15:8]);
		end else begin
			str_bytes.push_back(u[15:8]);
			str_bytes.push_back(u[7:0]);
		end
	endfunction

	function automatic void put32(input logic [31:0] v, input logic little);
		if (little) begin
			str_bytes.push_back(v[7:0]);
			str_bytes.push_back(v[15:8]);
			str_bytes.push_back(v[23:16]);
			str_bytes.push_back(v[31:24]);
		end else begin
			str_bytes.push_back(v[31:24]);
			str_bytes.push_back(v[23:16]);
			str_bytes.push_back(v[15:8]);
			str_bytes.push_back(v[7:0]);
		end
	endfunction

	// Builds one string for the given charset: for UTF-16 and UTF-32, mostly well-formed units with
	// random content, with lone surrogates, stray bytes and cut-off tails mixed in; else random bytes.
	function automatic void build_string(input logic [2:0] mode);
		logic little;
		logic [15:0] u;
		logic [31:0] v;
		int units;
		str_bytes.delete();
		if (mode == MODE_U16BE || mode == MODE_U16LE || mode == MODE_U16BOM) begin
			little = (mode == MODE_U16LE);
			if ($urandom_range(0, 2) == 0) begin
				if (mode == MODE_U16BOM) begin
					little = 1'($urandom_range(0, 1));
				end
				put16(BOM16_BE, little);
			end
			units = $urandom_range(1, 4);
			repeat (units) begin
				case ($urandom_range(0, 10))
					0: put16(16'($urandom_range(0, 'h7f)), little);
					1: put16(16'($urandom_range('h80, 'h7ff)), little);
					2: put16(16'($urandom_range('h800, 'hd7ff)), little);
					3: put16(16'($urandom_range('he000, 'hffff)), little);
					4, 5: begin
						put16(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), little);
						put16(16'($urandom_range(LOW_FIRST, LOW_LAST)), little);
					end
					6: put16(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), little);
					7: put16(16'($urandom_range(LOW_FIRST, LOW_LAST)), little);
					8: put16(16'($urandom), little);
					9: str_bytes.push_back(8'($urandom));
					default: begin
						case ($urandom_range(0, 3))
							0: u = 16'h0000;
							1: u = 16'hffff;
							2: u = HIGH_FIRST;
							default: u = LOW_LAST;
						endcase
						put16(u, little);
					end
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				str_bytes.push_back(8'($urandom));
			end
		end else if (mode == MODE_U32) begin
			little = 1'b0;
			if ($urandom_range(0, 2) == 0) begin
				little = 1'($urandom_range(0, 1));
				put32(BOM32_BE, little);
			end
			units = $urandom_range(1, 3);
			repeat (units) begin
				case ($urandom_range(0, 10))
					0: put32($urandom_range(0, 'h7f), little);
					1: put32($urandom_range('h80, 'hffff), little);
					2: put32($urandom_range('h10000, 'h10ffff), little);
					3, 4: begin
						put32($urandom_range(HIGH_FIRST, HIGH_LAST), little);
						put32($urandom_range(LOW_FIRST, LOW_LAST), little);
					end
					5: put32($urandom_range(HIGH_FIRST, HIGH_LAST), little);
					6: put32($urandom_range(LOW_FIRST, LOW_LAST), little);
					7: put32($urandom_range(32'hffffffff, 32'h00110000), little);
					8: put32($urandom, little);
					9: str_bytes.push_back(8'($urandom));
					default: begin
						case ($urandom_range(0, 3))
							0: v = 32'h00000000;
							1: v = CP_MAX32;
							2: v = CP_MAX32 + 32'd1;
							default: v = 32'hffffffff;
						endcase
						put32(v, little);
					end
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom));
			end
		end else begin
			repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom));
		end
	endfunction

	// Entered and left just after a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input logic [2:0] n_typed, input logic [31:0] typed_bytes);
		int gap;
		out_item_t item;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.in_byte = b;
		in_ch.string_end = fin;
		do @(posedge clk); while (!in_ch.ready);
		transcode_byte(b, fin);
		if (typed) begin
			for (int i = 0; i < n_typed; i++) begin
				item.data = typed_bytes[31 - 8 * i -: 8];
				item.last = (i == n_typed - 1);
				utf8_due.push_back(item);
			end
		end else begin
			for (int i = 0; i < step_bytes.size(); i++) begin
				item.data = step_bytes[i];
				item.last = (i == step_bytes.size() - 1);
				utf8_due.push_back(item);
			end
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic await_drain();
		while (utf8_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_mode(input logic [2:0] m);
		in_ch.valid = 1'b0;
		await_drain();
		// A byte that completes no character may still be in flight after the last output.
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = m;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cs_mode = m;
		clear_string_state();
		mode_writes++;
	endtask

	// Output side: random stalls, then every transfer is compared with the oldest expectation.
	initial begin
		int gap;
		out_item_t want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			bytes_checked++;
			if (utf8_due.size() == 0) begin
				$display("%0t: unexpected output byte %02h run_last %0b", $time,
					out_ch.out_byte, out_ch.run_last);
				mismatches++;
			end else begin
				want = utf8_due.pop_front();
				if (out_ch.out_byte !== want.data) begin
					$display("%0t: out_byte expected %02h actual %02h", $time, want.data,
						out_ch.out_byte);
					mismatches++;
				end
				if (out_ch.run_last !== want.last) begin
					$display("%0t: run_last expected %0b actual %0b", $time, want.last,
						out_ch.run_last);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d output bytes outstanding", $time, utf8_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [2:0] m;
		logic fin;
		int phase;
		int n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MODE_ASCII;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.string_end = 1'b0;
		burst = 1'b0;
		cs_mode = MODE_ASCII;
		clear_string_state();

		//      wr  mode          byte   end typed n  expected bytes
		add_row(1, MODE_SPARE7, 8'h80, 1, 1, 3, 32'hefbfbd00);
		add_row(1, MODE_ASCII,  8'h7f, 0, 1, 1, 32'h7f000000);
		add_row(0, MODE_ASCII,  8'h00, 1, 1, 1, 32'h00000000);
		add_row(1, MODE_LATIN1, 8'hff, 1, 1, 2, 32'hc3bf0000);
		// Surrogate pair, then a lone low surrogate, then a high one before a plain unit.
		add_row(1, MODE_U16BE,  8'hd8, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h3d, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'hde, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'hdc, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'hd8, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h41, 0, 0, 0, 32'h0);
		// A held high surrogate and a partial unit at the end give one replacement.
		add_row(0, MODE_U16BE,  8'hd8, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BE,  8'h7a, 1, 1, 3, 32'hefbfbd00);
		// Little-endian byte order mark, then the euro sign.
		add_row(1, MODE_U16BOM, 8'hff, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BOM, 8'hfe, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BOM, 8'hac, 0, 0, 0, 32'h0);
		add_row(0, MODE_U16BOM, 8'h20, 1, 0, 0, 32'h0);
		// A charset change in the middle of a string drops the partial unit.
		add_row(1, MODE_U32,    8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U32,    8'h00, 0, 0, 0, 32'h0);
		add_row(0, MODE_U32,    8'hd8, 0, 0, 0, 32'h0);
		add_row(1, MODE_SPARE6, 8'h41, 1, 1, 1, 32'h41000000);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].wr) begin
				write_mode(plan[i].mode);
			end
			send_byte(plan[i].data, plan[i].fin, plan[i].typed, plan[i].n, plan[i].want);
		end

		phase = 0;
		while (phase < 8 || bytes_sent < plan.size() + RANDOM_BYTES) begin
			m = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
			write_mode(m);
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				build_string(m);
				n = str_bytes.size();
				// Now and then a string runs on into the next one without its end marker.
				fin = ($urandom_range(0, 5) != 0);
				for (int i = 0; i < n; i++) begin
					send_byte(str_bytes[i], fin && (i == n - 1), 1'b0, 3'd0, 32'h0);
				end
				if (phase == 3) begin
					in_ch.valid = 1'b0;
					await_drain();
				end
			end
			phase++;
		end

		in_ch.valid = 1'b0;
		await_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d input bytes over %0d charset writes, all eight mode codes,",
			bytes_sent, mode_writes);
		$display("and compared %0d UTF-8 output bytes; %0d mismatches.", bytes_checked,
			mismatches);
		if (mismatches == 0 && utf8_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
